// ----- design/utf8_stream_decoder_assert.svh -----
// Assertion macros used by the UTF-8 stream decoder top level.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define U8D_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8d assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8d assertion failed");

`endif

// ----- design/u8d_pkg.sv -----
// Types and constants shared by the UTF-8 stream decoder modules.
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int CP_W = 21;

   // replacement code point for malformed input ('?')
   localparam logic [CP_W-1:0] QMARK_CP = 21'd63;

   // decoder state between bytes
   typedef struct packed {
      logic [CP_W-1:0] partial;
      logic [1:0]      needed;   // 0 means no open sequence
      logic [1:0]      taken;
   } dec_state_type;

   // results caused by one byte: qmarks '?' first, then cp if has_cp
   typedef struct packed {
      logic [1:0]      qmarks;
      logic            has_cp;
      logic [CP_W-1:0] cp;
   } dec_result_type;

endpackage

// ----- design/u8d_decode.sv -----
// Byte decoder: results and next state for one UTF-8 byte.
`timescale 1ns / 1ps

module u8d_decode (
   input  logic [7:0]             in_byte,
   input  u8d_pkg::dec_state_type state_cur,
   output u8d_pkg::dec_state_type state_nxt,
   output u8d_pkg::dec_result_type result
);

   logic is_cont;
   logic open_seq;
   logic [1:0] taken_inc;
   logic [u8d_pkg::CP_W-1:0] shifted;

   assign is_cont   = (in_byte[7:6] == 2'b10);
   assign open_seq  = (state_cur.needed != 2'd0);
   assign taken_inc = state_cur.taken + 2'd1;
   assign shifted   = {state_cur.partial[u8d_pkg::CP_W-7:0], in_byte[5:0]};

   always_comb begin
      state_nxt = '0;
      result    = '0;
      if (open_seq && is_cont) begin
         // continuation: append six bits, emit when complete
         if (taken_inc >= state_cur.needed) begin
            result.has_cp = 1'b1;
            result.cp     = shifted;
         end else begin
            state_nxt.partial = shifted;
            state_nxt.needed  = state_cur.needed;
            state_nxt.taken   = taken_inc;
         end
      end else begin
         // broken sequence: '?' for the lead and each continuation taken
         if (open_seq) begin
            result.qmarks = taken_inc;
         end
         // byte handled with no sequence open
         priority if (in_byte == 8'h00) begin
            // end of text, nothing to emit
         end else if (in_byte[7] == 1'b0) begin
            result.has_cp = 1'b1;
            result.cp     = {13'd0, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            state_nxt.partial = {16'd0, in_byte[4:0]};
            state_nxt.needed  = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            state_nxt.partial = {17'd0, in_byte[3:0]};
            state_nxt.needed  = 2'd2;
         end else if (in_byte[7:3] == 5'b11110) begin
            state_nxt.partial = {18'd0, in_byte[2:0]};
            state_nxt.needed  = 2'd3;
         end else begin
            // stray continuation or invalid lead
            result.has_cp = 1'b1;
            result.cp     = u8d_pkg::QMARK_CP;
         end
      end
   end

endmodule

// ----- design/u8d_out.sv -----
// Result register for the decoded code point word stream.
`timescale 1ns / 1ps

module u8d_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [u8d_pkg::CP_W-1:0] load_cp,
   input  logic                     load_last,
   output logic                     slot_free,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic                     rsp_tlast    // last_of_run
);

   logic                     valid_ff, valid_in;
   logic [u8d_pkg::CP_W-1:0] cp_ff;
   logic                     last_ff;

   // register may take a new word when empty or being drained
   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff   <= load_cp;
         last_ff <= load_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, cp_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_assert.svh"

// UTF-8 stream decoder: takes one text byte per input word and returns
// decoded code points, one per output word, with tlast on the final word
// caused by each byte. A byte is held in an input register, decoded there
// against the sequence state and its results go to a single result
// register. Well-formed text runs at one byte per cycle while the result
// register is not blocked; a lead or a middle continuation byte produces no
// word. A byte that breaks an open sequence produces up to four words and
// holds the input register until all of them are loaded, since the result
// register takes one word per cycle when free. A zero byte ends the text and
// produces no word of its own. Malformed input yields '?' (63).
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [20:0] code_point, [23:21] zero
   output logic        rsp_tlast     // last_of_run
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic [1:0]              idx_ff, idx_in;
   u8d_pkg::dec_state_type  state_ff, state_nxt;
   u8d_pkg::dec_result_type result;

   logic                     slot_free;
   logic [2:0]               total;
   logic                     emit_now;
   logic                     is_last;
   logic                     consume;
   logic [u8d_pkg::CP_W-1:0] emit_cp;

   u8d_decode u_decode (
      .in_byte   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (result)
   );

   // walk through the results of the held byte, one word per cycle while the result register is free
   assign total    = {1'b0, result.qmarks} + {2'd0, result.has_cp};
   assign is_last  = ({1'b0, idx_ff} == (total - 3'd1));
   assign emit_now = in_valid_ff && slot_free && (total != 3'd0);
   assign consume  = in_valid_ff && ((total == 3'd0) || (slot_free && is_last));
   assign emit_cp  = (idx_ff < result.qmarks) ? u8d_pkg::QMARK_CP : result.cp;

   assign req_tready  = !in_valid_ff || consume;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !consume);

   always_comb begin
      idx_in = idx_ff;
      if (consume) begin
         idx_in = 2'd0;
      end else if (emit_now) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // control and sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idx_ff      <= 2'd0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         idx_ff      <= idx_in;
         if (consume) begin
            state_ff <= state_nxt;
         end
      end
   end

   // input byte
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   u8d_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_now),
      .load_cp    (emit_cp),
      .load_last  (is_last),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // word index only runs while a byte is held
   `U8D_ASSERT_SAME(a_idx_needs_byte, clock, reset, idx_ff != 2'd0, in_valid_ff)
   // a blocked result register freezes the word index
   `U8D_ASSERT_NEXT(a_idx_holds, clock, reset, in_valid_ff && !slot_free, $stable(idx_ff))
   // sequence state moves only when a byte retires
   `U8D_ASSERT_NEXT(a_state_holds, clock, reset, !consume, $stable(state_ff))
   // a byte is never taken while the held one still has words to send
   `U8D_ASSERT_SAME(a_no_overrun, clock, reset, in_valid_ff && !consume, !req_tready)

endmodule

// ----- test/tb_utf8_stream_decoder.sv -----
// Self-checking testbench for the UTF-8 stream decoder, with random stalls on both sides.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

   localparam int CLK_PERIOD  = 12;
   localparam int RANDOM_BYTES = 250;
   localparam int DRAIN_CYCLES = 20;

   // one expected output word
   typedef struct {
      logic [u8d_pkg::CP_W-1:0] code;
      logic                     last;
   } point_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [20:0] code_point, [23:21] zero
   logic        rsp_tlast;    // last_of_run

   // decoder state mirrored by the predictor
   logic [u8d_pkg::CP_W-1:0] seq_code;
   logic [1:0]               seq_need;
   logic [1:0]               seq_taken;

   point_word_type expected_points[$];
   int          error_count;
   int          bytes_sent;
   bit          steady_send;      // sender offers words back to back
   bit          steady_recv;      // receiver never stalls
   int          recv_hold_cycles; // long receiver hold-off request

   utf8_stream_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   task automatic push_point(input logic [u8d_pkg::CP_W-1:0] code);
      point_word_type w;
      w.code = code;
      w.last = 1'b0;
      expected_points.push_back(w);
   endtask

   // close the mirrored sequence
   task automatic close_seq();
      seq_code  = '0;
      seq_need  = 2'd0;
      seq_taken = 2'd0;
   endtask

   // work out the code points that one accepted byte produces
   task automatic decode_byte(input logic [7:0] b);
      int unsigned before_cnt;
      before_cnt = expected_points.size();
      if (seq_need != 2'd0 && b[7:6] == 2'b10) begin
         // continuation of an open sequence
         seq_code  = {seq_code[u8d_pkg::CP_W-7:0], b[5:0]};
         seq_taken = seq_taken + 2'd1;
         if (seq_taken >= seq_need) begin
            push_point(seq_code);
            close_seq();
         end
      end else begin
         // broken sequence: '?' for the lead and each taken continuation
         if (seq_need != 2'd0) begin
            for (int i = 0; i <= seq_taken && i < 3; i++) push_point(u8d_pkg::QMARK_CP);
            close_seq();
         end
         if (b == 8'h00) begin
            // end of text, no word of its own
         end else if (b[7] == 1'b0) begin
            push_point({13'd0, b});
         end else if (b[7:5] == 3'b110) begin
            seq_code = {16'd0, b[4:0]};
            seq_need = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            seq_code = {17'd0, b[3:0]};
            seq_need = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            seq_code = {18'd0, b[2:0]};
            seq_need = 2'd3;
         end else begin
            // stray continuation or invalid lead
            push_point(u8d_pkg::QMARK_CP);
         end
      end
      if (expected_points.size() > before_cnt)
         expected_points[expected_points.size() - 1].last = 1'b1;
   endtask

   // offer one byte, wait for it to be taken, then maybe idle
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      decode_byte(b);
      bytes_sent++;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic stop_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_all_points();
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // one well-formed character of 1 to 4 bytes with random content
   task automatic send_char(input int unsigned len);
      logic [7:0] lead;
      case (len)
         1: lead = 8'($urandom_range(1, 127));
         2: lead = 8'hC0 | 8'($urandom_range(0, 31));
         3: lead = 8'hE0 | 8'($urandom_range(0, 15));
         default: lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      send_byte(lead);
      for (int k = 1; k < len; k++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
   endtask

   // a multi-byte character cut short by a byte that is no continuation
   task automatic send_broken(input int unsigned len);
      logic [7:0] breaker;
      int unsigned taken;
      taken = $urandom_range(0, len - 2);
      case (len)
         2: send_byte(8'hC0 | 8'($urandom_range(0, 31)));
         3: send_byte(8'hE0 | 8'($urandom_range(0, 15)));
         default: send_byte(8'hF0 | 8'($urandom_range(0, 7)));
      endcase
      for (int k = 0; k < taken; k++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
      if ($urandom_range(0, 4) == 0) begin
         breaker = 8'h00;
      end else begin
         do breaker = 8'($urandom_range(0, 255)); while (breaker[7:6] == 2'b10);
      end
      send_byte(breaker);
   endtask

   // extremes, every sequence length and each malformed case
   task automatic test_directed();
      logic [7:0] seq[$];
      seq = {8'h7F, 8'h00, 8'h01,
             8'hC2, 8'hA9,                  // two-byte
             8'hE2, 8'h82, 8'hAC,           // three-byte
             8'hF7, 8'hBF, 8'hBF, 8'hBF,    // largest four-byte value
             8'hC0, 8'h80,                  // overlong form
             8'h80, 8'hFF,                  // stray continuation, invalid lead
             8'hF0, 8'h9F, 8'h98, 8'h41,    // broken four-byte, four words
             8'hE2, 8'hC3, 8'hA9,           // broken by a new lead
             8'hF0, 8'h00};                 // flushed by end of text
      foreach (seq[i]) send_byte(seq[i]);
      stop_sender();
   endtask

   // mostly well-formed text, some broken sequences and raw noise
   task automatic test_random_text();
      int unsigned kind;
      int start_cnt;
      start_cnt = bytes_sent;
      while (bytes_sent - start_cnt < RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) send_char($urandom_range(1, 4));
         else if (kind < 85) send_broken($urandom_range(2, 4));
         else send_byte(8'($urandom_range(0, 255)));
      end
      stop_sender();
   endtask

   // receiver holds off while the sender keeps offering multi-word bytes
   task automatic test_backpressure();
      steady_send = 1'b1;
      recv_hold_cycles = 120;
      repeat (6) begin
         send_byte(8'hF0);
         send_byte(8'h9F);
         send_byte(8'h98);
         send_byte(8'hFF);
      end
      stop_sender();
      steady_send = 1'b0;
   endtask

   // sender pauses until everything is out, then a stretch with no idling
   task automatic test_drain_pause();
      repeat (8) send_char($urandom_range(1, 4));
      stop_sender();
      wait_all_points();
      steady_send = 1'b1;
      steady_recv = 1'b1;
      repeat (6) send_char($urandom_range(1, 4));
      send_broken(4);
      stop_sender();
      steady_send = 1'b0;
      steady_recv = 1'b0;
   endtask

   // receiver ready, with random stalls and the long hold-off
   initial begin
      int unsigned gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (recv_hold_cycles - 1) @(negedge clock);
            recv_hold_cycles = 0;
         end else begin
            gap = steady_recv ? 0 : pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
   end

   // compare each output word with the oldest expected code point
   initial begin
      point_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata !== {3'b000, want.code}) begin
                  $display("%0t: code point mismatch, expected %h, actual %h",
                           $time, {3'b000, want.code}, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: tlast mismatch, expected %b, actual %b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      #(CLK_PERIOD * 200000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = 8'h00;
      error_count      = 0;
      bytes_sent       = 0;
      steady_send      = 1'b0;
      steady_recv      = 1'b0;
      recv_hold_cycles = 0;
      close_seq();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_text();
      test_backpressure();
      test_drain_pause();

      wait_all_points();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
